@@ design/ceq_pkg.sv @@
// Shared constants, types and arithmetic helpers for the biquad equalizer.
`timescale 1ns / 1ps

package ceq_pkg;

  localparam int NUM_BANDS    = 16;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int DELAY_WIDTH  = 40;
  localparam int MASK_WIDTH   = 16;
  localparam int NUM_COEFS    = 5;
  localparam int COEF_FRAC    = COEF_WIDTH - 5;

  localparam int BAND_W   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int BCNT_W   = $clog2(NUM_BANDS + 1);
  localparam int ADDR_W   = $clog2(NUM_BANDS * NUM_COEFS);
  localparam int PROD_W   = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int RND_W    = PROD_W - COEF_FRAC;
  localparam int ACC_W    = DELAY_WIDTH + 2;

  typedef logic [1:0] req_t;
  localparam req_t REQ_SAMPLE = 2'd0;
  localparam req_t REQ_COEF   = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;

  typedef logic [2:0] coef_idx_t;
  localparam coef_idx_t COEF_B0 = 3'd0;
  localparam coef_idx_t COEF_B1 = 3'd1;
  localparam coef_idx_t COEF_B2 = 3'd2;
  localparam coef_idx_t COEF_A1 = 3'd3;
  localparam coef_idx_t COEF_A2 = 3'd4;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = {5'd1, {COEF_FRAC{1'b0}}};
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (COEF_FRAC - 1));

  typedef struct packed {
    logic              vld;
    logic [BAND_W-1:0] band;
    coef_idx_t         cidx;
  } ceq_op_t;

  typedef struct packed {
    logic    load_sample;
    logic    coef_wr;
    logic    clear;
    logic    out_load;
    ceq_op_t op;
  } ceq_cmd_t;

  typedef struct packed {
    logic busy;
  } ceq_sts_t;

  function automatic logic [ADDR_W-1:0] coef_addr(input logic [BAND_W-1:0] band,
                                                  input coef_idx_t idx);
    return ADDR_W'(int'(band) * NUM_COEFS + int'(idx));
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
    if (&v[ACC_W-1:SAMPLE_WIDTH-1] || ~|v[ACC_W-1:SAMPLE_WIDTH-1]) begin
      return v[SAMPLE_WIDTH-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
      input logic signed [ACC_W-1:0] v);
    if (&v[ACC_W-1:DELAY_WIDTH-1] || ~|v[ACC_W-1:DELAY_WIDTH-1]) begin
      return v[DELAY_WIDTH-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DELAY_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(DELAY_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/ceq_ctrl.sv @@
// Controller that sequences the five products of every active band and the result handshake.
`timescale 1ns / 1ps

module ceq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ceq_pkg::req_t               in_req_type,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        cfg_wr_en,
  input  logic [ceq_pkg::MASK_WIDTH-1:0] cfg_wr_data,
  input  ceq_pkg::ceq_sts_t           sts,
  output ceq_pkg::ceq_cmd_t           cmd
);
  import ceq_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [BCNT_W-1:0]     band_r, band_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [MASK_WIDTH-1:0] mask_r, mask_nxt;
  ceq_op_t               iss_r, iss_nxt;
  logic                  out_vld_r, out_vld_nxt;

  logic                  accept;
  logic                  out_load;
  logic [NUM_BANDS-1:0]  band_en;
  logic [BAND_W-1:0]     band_idx;

  function automatic coef_idx_t step_coef(input logic [2:0] step);
    case (step)
      3'd0:    return COEF_B0;
      3'd1:    return COEF_B1;
      3'd2:    return COEF_A1;
      3'd3:    return COEF_B2;
      default: return COEF_A2;
    endcase
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign band_en  = NUM_BANDS'(mask_r);
  assign band_idx = band_r[BAND_W-1:0];

  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    step_nxt  = step_r;
    mask_nxt  = cfg_wr_en ? cfg_wr_data : mask_r;
    iss_nxt   = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_SAMPLE)) begin
          state_nxt = ST_RUN;
          band_nxt  = '0;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (band_r == BCNT_W'(NUM_BANDS)) begin
          state_nxt = ST_DRAIN;
        end else if (!band_en[band_idx]) begin
          band_nxt = band_r + 1'b1;
        end else begin
          iss_nxt.vld  = 1'b1;
          iss_nxt.band = band_idx;
          iss_nxt.cidx = step_coef(step_r);
          if (step_r == 3'(NUM_COEFS - 1)) begin
            step_nxt = '0;
            band_nxt = band_r + 1'b1;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!iss_r.vld && !sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      band_r    <= '0;
      step_r    <= '0;
      mask_r    <= '0;
      iss_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      band_r    <= band_nxt;
      step_r    <= step_nxt;
      mask_r    <= mask_nxt;
      iss_r     <= iss_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign cmd.load_sample  = accept && (in_req_type == REQ_SAMPLE);
  assign cmd.coef_wr      = accept && (in_req_type == REQ_COEF);
  assign cmd.clear        = accept && (in_req_type == REQ_CLEAR);
  assign cmd.out_load     = out_load;
  assign cmd.op           = iss_r;

  a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r.vld |-> $past(state_r) == ST_RUN)
    else $error("product issued outside the run phase");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!iss_r.vld && !sts.busy))
    else $error("result taken before the datapath had drained");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_vld_r || !out_stall))
    else $error("pending result overwritten");

endmodule

@@ design/ceq_datapath.sv @@
// Datapath: coefficient memory, shared multiplier, rounding, delay state and output register.
`timescale 1ns / 1ps

module ceq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ceq_pkg::ceq_cmd_t                   cmd,
  output ceq_pkg::ceq_sts_t                   sts,
  input  logic signed [ceq_pkg::SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                                in_frame_end,
  input  logic [3:0]                          in_band_select,
  input  ceq_pkg::coef_idx_t                  in_coef_index,
  input  logic signed [ceq_pkg::COEF_WIDTH-1:0]   in_coef_value,
  output logic signed [ceq_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                                out_frame_end_out
);
  import ceq_pkg::*;

  localparam int DEPTH = NUM_BANDS * NUM_COEFS;

  logic signed [COEF_WIDTH-1:0]   coef_mem [DEPTH];
  logic [DEPTH-1:0]               coef_vld_r;
  logic signed [COEF_WIDTH-1:0]   rd_data_r;
  logic                           rd_vld_r;
  logic                           rd_b0_r;
  logic signed [COEF_WIDTH-1:0]   coef_eff;
  logic [ADDR_W-1:0]              wr_addr;
  logic [ADDR_W-1:0]              rd_addr;
  logic                           wr_ok;

  ceq_op_t                        p1_r, p2_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r, y_r;
  logic signed [SAMPLE_WIDTH-1:0] operand;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [PROD_W-1:0]       rsum;
  logic signed [RND_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        rnd_ext;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [DELAY_WIDTH-1:0]  z1_r [NUM_BANDS];
  logic signed [DELAY_WIDTH-1:0]  z2_r [NUM_BANDS];
  logic                           frame_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_frame_r;

  assign wr_ok   = cmd.coef_wr && (int'(in_band_select) < NUM_BANDS)
                   && (int'(in_coef_index) < NUM_COEFS);
  assign wr_addr = coef_addr(BAND_W'(in_band_select), in_coef_index);
  assign rd_addr = coef_addr(cmd.op.band, cmd.op.cidx);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      coef_mem[wr_addr] <= in_coef_value;
    end
    rd_data_r <= coef_mem[rd_addr];
    rd_b0_r   <= (cmd.op.cidx == COEF_B0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_ok) begin
        coef_vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= coef_vld_r[rd_addr];
    end
  end

  // A coefficient that was never written reads as its reset value.
  assign coef_eff = rd_vld_r ? rd_data_r : (rd_b0_r ? COEF_ONE : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
    end else begin
      p1_r <= cmd.op;
      p2_r <= p1_r;
    end
  end

  assign operand = ((p1_r.cidx == COEF_B1) || (p1_r.cidx == COEF_B2)) ? x_r : y_r;

  always_ff @(posedge clk) begin
    prod_r <= coef_eff * operand;
    if (p1_r.vld && (p1_r.cidx == COEF_B0)) begin
      x_r <= y_r;
    end
  end

  assign rsum    = prod_r + ROUND_HALF;
  assign rnd     = rsum[PROD_W-1:COEF_FRAC];
  assign rnd_ext = ACC_W'(rnd);

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      y_r     <= in_sample_in;
      frame_r <= in_frame_end;
    end else if (p2_r.vld && (p2_r.cidx == COEF_B0)) begin
      y_r <= sat_sample(rnd_ext + ACC_W'(z1_r[p2_r.band]));
    end
    if (p2_r.vld && ((p2_r.cidx == COEF_B1) || (p2_r.cidx == COEF_B2))) begin
      acc_r <= rnd_ext;
    end
    if (cmd.out_load) begin
      out_sample_r <= y_r;
      out_frame_r  <= frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        z1_r[i] <= '0;
        z2_r[i] <= '0;
      end
    end else if (p2_r.vld) begin
      case (p2_r.cidx)
        COEF_A1: z1_r[p2_r.band] <= sat_delay(acc_r - rnd_ext
                                              + ACC_W'(z2_r[p2_r.band]));
        COEF_A2: z2_r[p2_r.band] <= sat_delay(acc_r - rnd_ext);
        default: ;
      endcase
    end
  end

  assign sts.busy          = p1_r.vld || p2_r.vld;
  assign out_sample_out    = out_sample_r;
  assign out_frame_end_out = out_frame_r;

endmodule

@@ design/cascaded_biquad_equalizer.sv @@
// Top level of the cascaded biquad equalizer: controller and datapath.
// A sample request gives one result after all active bands have run; bands whose mask bit is
// clear are bypassed. The next request is accepted as the result appears. Coefficient writes
// and clear requests give no result.
// Synchronous active-low reset clears the mask and delays and sets b0 = 1.0, others zero.
`timescale 1ns / 1ps

module cascaded_biquad_equalizer (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_req_type,
  input  logic signed [ceq_pkg::SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                                    in_frame_end,
  input  logic [3:0]                              in_band_select,
  input  logic [2:0]                              in_coef_index,
  input  logic signed [ceq_pkg::COEF_WIDTH-1:0]   in_coef_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ceq_pkg::SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                                    out_frame_end_out,
  input  logic                                    cfg_wr_en,
  input  logic [ceq_pkg::MASK_WIDTH-1:0]          cfg_wr_data
);
  import ceq_pkg::*;

  ceq_cmd_t cmd;
  ceq_sts_t sts;

  ceq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd)
  );

  ceq_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample_in      (in_sample_in),
    .in_frame_end      (in_frame_end),
    .in_band_select    (in_band_select),
    .in_coef_index     (in_coef_index),
    .in_coef_value     (in_coef_value),
    .out_sample_out    (out_sample_out),
    .out_frame_end_out (out_frame_end_out)
  );

endmodule
